/* hw/rtl/deque_with_value_removal_assert.svh */
// Assertion macros used by the checker of the deque block.
`ifndef DEQUE_WITH_VALUE_REMOVAL_ASSERT_SVH
`define DEQUE_WITH_VALUE_REMOVAL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DWVR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DWVR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/dwvr_pkg.sv */
// Package with the types, codes and index helpers of the deque block.
package dwvr_pkg;

	localparam int DEPTH = 16;
	localparam int VAL_W = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = IDX_W + 2;

	localparam logic [2:0] OPC_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OPC_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OPC_POP_FRONT  = 3'd2;
	localparam logic [2:0] OPC_POP_BACK   = 3'd3;
	localparam logic [2:0] OPC_REMOVE     = 3'd4;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_REMOVE,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE,
		ST_FULL,
		ST_EMPTY,
		ST_NOTFOUND
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		status_t          status;
		logic [CNT_W-1:0] count;
		logic [VAL_W-1:0] front;
		logic [VAL_W-1:0] back;
	} res_t;

	// Physical slot of the entry at a given distance from the head.
	function automatic logic [IDX_W-1:0] slot_idx(input logic [IDX_W-1:0] head,
			input logic [CNT_W-1:0] offset);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(head) + SUM_W'(offset);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

/* hw/rtl/dwvr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module dwvr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/dwvr_front.sv */
// Front end: accepts input words, decodes the operation and queues commands.
module dwvr_front import dwvr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [2:0]       operation,
	input  logic [VAL_W-1:0] value,
	output logic             cmd_valid,
	output cmd_t             cmd,
	input  logic             cmd_take
);

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	op_t        op_dec;
	logic       do_wr;
	logic       do_rd;

	always_comb begin
		unique case (operation)
			OPC_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
			OPC_PUSH_BACK:  op_dec = OP_PUSH_BACK;
			OPC_POP_FRONT:  op_dec = OP_POP_FRONT;
			OPC_POP_BACK:   op_dec = OP_POP_BACK;
			OPC_REMOVE:     op_dec = OP_REMOVE;
			default:        op_dec = OP_NOP;
		endcase
	end

	assign full      = (fill_q == 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = ent_q[rd_ptr_q];
	assign do_wr     = push && !full;
	assign do_rd     = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wr_ptr_q] <= '{op: op_dec, value: value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

/* hw/rtl/dwvr_back.sv */
// Back end: executes commands on the circular store and holds the result word.
module dwvr_back import dwvr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_take,
	output logic res_valid,
	output res_t res,
	input  logic res_pop
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_REF_F,
		S_REF_B,
		S_REF_W,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VAL_W-1:0] front_q;
	logic [VAL_W-1:0] back_q;
	logic [VAL_W-1:0] val_q;
	logic [CNT_W-1:0] nxt_q;
	logic [CNT_W-1:0] chk_q;
	logic [CNT_W-1:0] k_q;
	logic             pend_s1;
	status_t          st_q;
	res_t             res_q;
	logic             res_valid_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [VAL_W-1:0] ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic [VAL_W-1:0] ram_rdata;

	logic             is_full;
	logic             is_empty;
	logic [IDX_W-1:0] head_dec;
	logic [CNT_W-1:0] k_inc;
	logic             more_shift;

	assign is_full    = (cnt_q == CNT_W'(DEPTH));
	assign is_empty   = (cnt_q == '0);
	assign head_dec   = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - 1'b1;
	assign k_inc      = k_q + 1'b1;
	assign more_shift = (k_inc < cnt_q);
	assign cmd_take   = (state_q == S_IDLE) && !res_valid_q && cmd_valid;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_idx(head_q, cnt_q);
		ram_wdata = cmd.value;
		ram_raddr = slot_idx(head_q, nxt_q);
		unique case (state_q)
			S_IDLE: begin
				if (cmd_take && !is_full) begin
					if (cmd.op == OP_PUSH_FRONT) begin
						ram_we    = 1'b1;
						ram_waddr = head_dec;
					end else if (cmd.op == OP_PUSH_BACK) begin
						ram_we    = 1'b1;
					end
				end
			end
			S_SHIFT: begin
				if (more_shift) begin
					ram_we    = 1'b1;
					ram_waddr = slot_idx(head_q, k_q);
					ram_wdata = ram_rdata;
					ram_raddr = slot_idx(head_q, k_inc + 1'b1);
				end
			end
			S_REF_F: ram_raddr = slot_idx(head_q, '0);
			S_REF_B: ram_raddr = slot_idx(head_q, cnt_q - 1'b1);
			default: ;
		endcase
	end

	dwvr_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			cnt_q       <= '0;
			front_q     <= '0;
			back_q      <= '0;
			val_q       <= '0;
			nxt_q       <= '0;
			chk_q       <= '0;
			k_q         <= '0;
			pend_s1     <= 1'b0;
			st_q        <= ST_DONE;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						st_q    <= ST_DONE;
						state_q <= S_DONE;
						unique case (cmd.op)
							OP_PUSH_FRONT: begin
								if (is_full) begin
									st_q <= ST_FULL;
								end else begin
									head_q  <= head_dec;
									cnt_q   <= cnt_q + 1'b1;
									front_q <= cmd.value;
									if (is_empty) begin
										back_q <= cmd.value;
									end
								end
							end
							OP_PUSH_BACK: begin
								if (is_full) begin
									st_q <= ST_FULL;
								end else begin
									cnt_q  <= cnt_q + 1'b1;
									back_q <= cmd.value;
									if (is_empty) begin
										front_q <= cmd.value;
									end
								end
							end
							OP_POP_FRONT, OP_POP_BACK: begin
								if (is_empty) begin
									st_q <= ST_EMPTY;
								end else begin
									cnt_q   <= cnt_q - 1'b1;
									state_q <= S_REF_F;
									if (cnt_q == CNT_W'(1)) begin
										head_q <= '0;
									end else if (cmd.op == OP_POP_FRONT) begin
										head_q <= slot_idx(head_q, CNT_W'(1));
									end
								end
							end
							OP_REMOVE: begin
								val_q <= cmd.value;
								if (is_empty) begin
									st_q <= ST_NOTFOUND;
								end else begin
									nxt_q   <= '0;
									pend_s1 <= 1'b0;
									state_q <= S_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					nxt_q   <= nxt_q + 1'b1;
					chk_q   <= nxt_q;
					pend_s1 <= (nxt_q < cnt_q);
					if (pend_s1) begin
						if (ram_rdata == val_q) begin
							k_q     <= chk_q;
							state_q <= S_SHIFT;
						end else if (chk_q == cnt_q - 1'b1) begin
							st_q    <= ST_NOTFOUND;
							state_q <= S_DONE;
						end
					end
				end
				S_SHIFT: begin
					if (more_shift) begin
						k_q <= k_inc;
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						st_q    <= ST_DONE;
						state_q <= S_REF_F;
						if (cnt_q == CNT_W'(1)) begin
							head_q <= '0;
						end
					end
				end
				S_REF_F: begin
					state_q <= is_empty ? S_DONE : S_REF_B;
				end
				S_REF_B: begin
					front_q <= ram_rdata;
					state_q <= S_REF_W;
				end
				S_REF_W: begin
					back_q  <= ram_rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					res_q.status <= st_q;
					res_q.count  <= cnt_q;
					res_q.front  <= is_empty ? '0 : front_q;
					res_q.back   <= is_empty ? '0 : back_q;
					res_valid_q  <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/deque_with_value_removal.sv */
// Pushes and undefined codes go straight to the result word; pops first reload the cached ends from the store.
// Remove by value scans the held entries from the front, then closes up the gap left by the match.
// One word is executed at a time; the RAM read port paces the scan and close-up.
// Two commands queue in front of the execution engine, and one result word waits at the output.
// Reset (arst_n low) is asynchronous: the list becomes empty and all queues are cleared.
// The entry memory is not cleared; only entries inside the held range are ever used.
module deque_with_value_removal import dwvr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [2:0]              operation,
	input  logic signed [VAL_W-1:0] value,
	output logic                    empty,
	input  logic                    pop,
	output logic [1:0]              status,
	output logic [CNT_W-1:0]        entry_count,
	output logic signed [VAL_W-1:0] front_value,
	output logic signed [VAL_W-1:0] back_value
);

	// Commands flow from the decoder queue into the engine when it is idle
	// and its result register has been drained.
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_take;
	logic res_valid;
	res_t res;

	// The front end decodes the operation code and buffers two commands,
	// so new words are accepted while the engine is still busy.
	dwvr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.operation(operation),
		.value    (value),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take)
	);

	// The back end owns the circular store, the head and count registers, and
	// the cached front and back values, and it presents one result word.
	dwvr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take),
		.res_valid(res_valid),
		.res      (res),
		.res_pop  (pop)
	);

	// The result word stays on the ports until it is popped.
	assign empty       = !res_valid;
	assign status      = res.status;
	assign entry_count = res.count;
	assign front_value = res.front;
	assign back_value  = res.back;

endmodule

/* hw/rtl/dwvr_checker.sv */
// Port-level checker for the deque block, bound to its top level.
`include "deque_with_value_removal_assert.svh"

module dwvr_checker import dwvr_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    push,
	input logic                    full,
	input logic [2:0]              operation,
	input logic signed [VAL_W-1:0] value,
	input logic                    empty,
	input logic                    pop,
	input logic [1:0]              status,
	input logic [CNT_W-1:0]        entry_count,
	input logic signed [VAL_W-1:0] front_value,
	input logic signed [VAL_W-1:0] back_value
);

	`DWVR_ASSERT_IMP(a_count_range, clk, arst_n, !empty, entry_count <= CNT_W'(DEPTH), "count exceeds depth")
	`DWVR_ASSERT_IMP(a_empty_zero, clk, arst_n, !empty && (entry_count == '0), (front_value == '0) && (back_value == '0), "empty list shows nonzero ends")
	`DWVR_ASSERT_IMP(a_full_refusal, clk, arst_n, !empty && (status == ST_FULL), entry_count == CNT_W'(DEPTH), "insert refused while not full")
	`DWVR_ASSERT_IMP(a_empty_status, clk, arst_n, !empty && (status == ST_EMPTY), entry_count == '0, "empty status with entries held")
	`DWVR_ASSERT_NXT(a_result_hold, clk, arst_n, !empty && !pop, !empty && $stable(entry_count) && $stable(front_value), "result word changed while waiting")

endmodule

bind deque_with_value_removal dwvr_checker u_checker (.*);
